// ===== hw/rtl/tdarb_pkg.sv =====
// Package for the two-level direction arbiter.
// Holds field widths, status codes, the classified command type and the
// back-end state type. No dependencies.
package tdarb_pkg;

  // Default number of entries in each of the four request queues
  localparam int QUEUE_DEPTH_DEF = 16;

  // Field widths
  localparam int KEY_W  = 10;
  localparam int ID_W   = 8;
  localparam int ST_W   = 2;
  localparam int NUM_Q  = 4;
  localparam int QSEL_W = 2;

  // Command queue between front and back end
  localparam int QF_DEPTH = 2;
  localparam int QF_AW    = 1;

  // Command and direction codes
  localparam logic CMD_GRANT = 1'b1;
  localparam logic DIR_WEST  = 1'b0;
  localparam logic DIR_EAST  = 1'b1;

  // Result status codes
  typedef enum logic [ST_W-1:0] {
    ST_ACCEPTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_GRANTED  = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  // Classified command handed from front end to back end
  typedef struct packed {
    logic             grant;
    logic             high;
    logic             dir;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } op_t;

  // One stored queue entry
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } entry_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    B_IDLE,
    B_INS,
    B_PUT,
    B_GNT,
    B_RESULT
  } back_state_t;

endpackage

// ===== hw/rtl/tdarb_ifs.sv =====
// Valid/ready channel interfaces for the arbiter's item and result streams.
// Depends on tdarb_pkg for field widths.
interface tdarb_in_if;
  import tdarb_pkg::*;

  logic             valid;
  logic             ready;
  logic             cmd;
  logic             direction;
  logic             high_priority;
  logic [KEY_W-1:0] sort_key;
  logic [ID_W-1:0]  requester_id;

  modport source (output valid, cmd, direction, high_priority, sort_key, requester_id,
                  input ready);
  modport sink   (input valid, cmd, direction, high_priority, sort_key, requester_id,
                  output ready);
endinterface

interface tdarb_out_if;
  import tdarb_pkg::*;

  logic            valid;
  logic            ready;
  logic [ST_W-1:0] status;
  logic [ID_W-1:0] granted_id;
  logic            granted_direction;
  logic            granted_high;

  modport source (output valid, status, granted_id, granted_direction, granted_high,
                  input ready);
  modport sink   (input valid, status, granted_id, granted_direction, granted_high,
                  output ready);
endinterface

// ===== hw/rtl/two_level_direction_arbiter.sv =====
// Top level of the two-level direction arbiter.
// Depends on tdarb_pkg, tdarb_ifs, tdarb_front, tdarb_fifo and tdarb_back.
//
// Four sorted request queues (high/low priority x west/east) of QUEUE_DEPTH
// entries each live in one single-port-write memory. An arrive item is
// inserted by walking from the queue tail toward the head, one entry per
// cycle, past the queued entries that sort after it; into an empty queue
// it is written at once, and a full queue refuses it. A grant item reads
// the chosen queue head. The front end and a two-entry command queue keep
// taking items while the back end works, and a result register holds each
// result until it is taken. No clearing pass is needed after reset.
module two_level_direction_arbiter #(
  parameter int QUEUE_DEPTH = tdarb_pkg::QUEUE_DEPTH_DEF
) (
  input logic          clk,
  input logic          rst_n,
  tdarb_in_if.sink     in_ch,
  tdarb_out_if.source  out_ch
);
  import tdarb_pkg::*;

  op_t  front_op, fifo_op;
  logic push, fifo_full, pop, fifo_empty;

  // Item intake and decode
  tdarb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .push_op   (front_op),
    .push      (push),
    .fifo_full (fifo_full)
  );

  // Command queue
  tdarb_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (front_op),
    .full    (fifo_full),
    .pop     (pop),
    .pop_op  (fifo_op),
    .empty   (fifo_empty)
  );

  // Queue keeping and grant
  tdarb_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_op     (fifo_op),
    .fifo_empty (fifo_empty),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

// ===== hw/rtl/tdarb_front.sv =====
// Front end: accepts input items, decodes them into commands and holds one
// in a register stage until the command queue takes it. Uses tdarb_pkg, tdarb_in_if.
module tdarb_front (
  input  logic             clk,
  input  logic             rst_n,
  tdarb_in_if.sink         in_ch,
  output tdarb_pkg::op_t   push_op,
  output logic             push,
  input  logic             fifo_full
);
  import tdarb_pkg::*;

  logic valid_r, valid_nxt;
  op_t  op_r, op_nxt;

  // Stage is free when empty or when its command moves on this cycle
  assign in_ch.ready = !valid_r || !fifo_full;
  assign push        = valid_r && !fifo_full;
  assign push_op     = op_r;

  // Decode the incoming item
  always_comb begin
    op_nxt.grant = (in_ch.cmd == CMD_GRANT);
    op_nxt.high  = in_ch.high_priority;
    op_nxt.dir   = in_ch.direction;
    op_nxt.key   = in_ch.sort_key;
    op_nxt.id    = in_ch.requester_id;
    valid_nxt    = in_ch.ready ? in_ch.valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r <= op_nxt;
    end
  end

endmodule

// ===== hw/rtl/tdarb_fifo.sv =====
// Short command queue between front and back end, built from registers.
// Uses tdarb_pkg for the command type and depth.
module tdarb_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tdarb_pkg::op_t push_op,
  output logic           full,
  input  logic           pop,
  output tdarb_pkg::op_t pop_op,
  output logic           empty
);
  import tdarb_pkg::*;

  op_t              slot_r [QF_DEPTH];
  logic [QF_AW-1:0] wp_r, rp_r;
  logic [QF_AW:0]   cnt_r;

  assign full   = (cnt_r == (QF_AW+1)'(QF_DEPTH));
  assign empty  = (cnt_r == '0);
  assign pop_op = slot_r[rp_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_op;
    end
  end

endmodule

// ===== hw/rtl/tdarb_back.sv =====
// Back end: four sorted request queues in one memory (circular per queue),
// sorted insert from the tail, strict-priority grant with direction
// alternation, and the result register. Uses tdarb_pkg, tdarb_out_if.
module tdarb_back #(
  parameter int QUEUE_DEPTH = tdarb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tdarb_pkg::op_t pop_op,
  input  logic           fifo_empty,
  output logic           pop,
  tdarb_out_if.source    out_ch
);
  import tdarb_pkg::*;

  localparam int AW        = $clog2(QUEUE_DEPTH);
  localparam int CW        = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_Q << AW;
  localparam logic [AW:0]   DEPTH_X = (AW+1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  // Offset within a circular queue: (base + ofs) mod depth
  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base,
                                         input logic [AW-1:0] ofs);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, ofs};
    if (s >= DEPTH_X) s = s - DEPTH_X;
    return s[AW-1:0];
  endfunction

  back_state_t state_r, state_nxt;

  // Queue bookkeeping
  logic [CW-1:0] cnt_r  [NUM_Q];
  logic [AW-1:0] head_r [NUM_Q];
  logic          last_r;

  // Entry memory
  entry_t mem [MEM_DEPTH];
  entry_t rdata_r;

  // Command being worked on
  logic [KEY_W-1:0]  key_r;
  logic [ID_W-1:0]   id_r;
  logic [QSEL_W-1:0] q_r;
  logic [AW-1:0]     i_r;
  logic              pick_r;

  // Pending result and output register
  status_t         res_status_r;
  logic [ID_W-1:0] res_id_r;
  logic            res_dir_r, res_high_r;
  logic            out_valid_r;
  status_t         out_status_r;
  logic [ID_W-1:0] out_id_r;
  logic            out_dir_r, out_high_r;

  // Decode and selection
  logic              arrive;
  logic              lvl, w_wait, e_wait, gnt_any, pick;
  logic [QSEL_W-1:0] sel_q;
  logic [CW-1:0]     n;
  logic [AW-1:0]     hd, nm1;
  logic              qfull, qempty, later;

  // Control
  logic                   mem_we, mem_re;
  logic [QSEL_W+AW-1:0]   waddr, raddr;
  entry_t                 wdata;
  logic                   cnt_inc, cnt_dec, out_load;

  // Grant choice: high level first, then alternate direction when both wait
  always_comb begin
    arrive  = !pop_op.grant;
    lvl     = (cnt_r[3] != '0) || (cnt_r[2] != '0);
    w_wait  = lvl ? (cnt_r[2] != '0) : (cnt_r[0] != '0);
    e_wait  = lvl ? (cnt_r[3] != '0) : (cnt_r[1] != '0);
    gnt_any = w_wait || e_wait;
    if (w_wait && e_wait) pick = ~last_r;
    else                  pick = w_wait ? DIR_WEST : DIR_EAST;
    if (state_r == B_IDLE) sel_q = arrive ? {pop_op.high, pop_op.dir} : {lvl, pick};
    else                   sel_q = q_r;
    n      = cnt_r[sel_q];
    hd     = head_r[sel_q];
    nm1    = AW'(n - CW'(1));
    qfull  = (n == DEPTH_C);
    qempty = (n == '0);
    later  = (rdata_r.key > key_r) || ((rdata_r.key == key_r) && (rdata_r.id > id_r));
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!fifo_empty) begin
          if (arrive) state_nxt = (qfull || qempty) ? B_RESULT : B_INS;
          else        state_nxt = gnt_any ? B_GNT : B_RESULT;
        end
      end
      B_INS: begin
        if (!later)          state_nxt = B_RESULT;
        else if (i_r == '0)  state_nxt = B_PUT;
      end
      B_PUT:    state_nxt = B_RESULT;
      B_GNT:    state_nxt = B_RESULT;
      B_RESULT: if (!out_valid_r || out_ch.ready) state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    pop      = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    waddr    = {sel_q, hd};
    raddr    = {sel_q, hd};
    wdata    = '{key: key_r, id: id_r};
    cnt_inc  = 1'b0;
    cnt_dec  = 1'b0;
    out_load = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!fifo_empty) begin
          pop = 1'b1;
          if (arrive) begin
            if (!qfull && qempty) begin
              mem_we  = 1'b1;
              wdata   = '{key: pop_op.key, id: pop_op.id};
              cnt_inc = 1'b1;
            end else if (!qfull) begin
              // start the walk at the tail entry
              mem_re = 1'b1;
              raddr  = {sel_q, wrap(hd, nm1)};
            end
          end else if (gnt_any) begin
            mem_re = 1'b1;
          end
        end
      end
      B_INS: begin
        // shift a later entry up one place, or drop the new one in behind it
        mem_we = 1'b1;
        waddr  = {sel_q, wrap(hd, AW'(i_r + AW'(1)))};
        if (later) begin
          wdata = rdata_r;
          if (i_r != '0) begin
            mem_re = 1'b1;
            raddr  = {sel_q, wrap(hd, AW'(i_r - AW'(1)))};
          end
        end else begin
          cnt_inc = 1'b1;
        end
      end
      B_PUT: begin
        mem_we  = 1'b1;
        cnt_inc = 1'b1;
      end
      B_GNT:    cnt_dec  = 1'b1;
      B_RESULT: out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      last_r      <= DIR_EAST;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_Q; k++) begin
        cnt_r[k]  <= '0;
        head_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cnt_inc)      cnt_r[sel_q] <= n + CW'(1);
      else if (cnt_dec) cnt_r[sel_q] <= n - CW'(1);
      if (state_r == B_GNT) begin
        head_r[sel_q] <= wrap(hd, AW'(1));
        last_r        <= pick_r;
      end
      if (out_load)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // Working registers and result
  always_ff @(posedge clk) begin
    if (pop) begin
      key_r  <= pop_op.key;
      id_r   <= pop_op.id;
      q_r    <= sel_q;
      i_r    <= nm1;
      pick_r <= pick;
      res_id_r <= '0;
      if (arrive) begin
        res_status_r <= qfull ? ST_FULL : ST_ACCEPTED;
        res_dir_r    <= 1'b0;
        res_high_r   <= 1'b0;
      end else if (gnt_any) begin
        res_status_r <= ST_GRANTED;
        res_dir_r    <= pick;
        res_high_r   <= lvl;
      end else begin
        res_status_r <= ST_NONE;
        res_dir_r    <= 1'b0;
        res_high_r   <= 1'b0;
      end
    end
    if (state_r == B_INS && later && i_r != '0) i_r <= i_r - AW'(1);
    if (state_r == B_GNT) res_id_r <= rdata_r.id;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
      out_dir_r    <= res_dir_r;
      out_high_r   <= res_high_r;
    end
  end

  // Entry memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (mem_re) rdata_r <= mem[raddr];
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = out_status_r;
  assign out_ch.granted_id        = out_id_r;
  assign out_ch.granted_direction = out_dir_r;
  assign out_ch.granted_high      = out_high_r;

  // Counts never pass the queue depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[0] <= DEPTH_C && cnt_r[1] <= DEPTH_C && cnt_r[2] <= DEPTH_C && cnt_r[3] <= DEPTH_C)
    else $error("queue count above depth");

  // The insert walk only runs over a non-empty queue
  a_ins_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_INS |-> cnt_r[q_r] != '0)
    else $error("insert walk on empty queue");

  // Last direction only moves on a grant
  a_last_dir: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(last_r) |-> $past(state_r) == B_GNT)
    else $error("last direction changed outside a grant");

  // Non-grant results carry zero grant fields
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_GRANTED |->
      out_id_r == '0 && !out_dir_r && !out_high_r)
    else $error("grant fields set on non-grant result");

endmodule
